// ===== hw/rtl/rtyc_pkg.sv =====
// ----------------------------------------------------------------------------
// rtyc_pkg
// Types and constants shared by the RGB to YUV 4:2:2 / 4:2:0 converter.
// ----------------------------------------------------------------------------
package rtyc_pkg;

  localparam int MAX_WIDTH_PAIRS = 2048;
  localparam int COEFF_FRAC_BITS = 16;

  localparam int PIX_W   = 8;
  localparam int POS_W   = 12;
  localparam int PAIR_AW = $clog2(MAX_WIDTH_PAIRS);
  localparam int SUM_W   = PIX_W + 1;
  localparam int LS_W    = 2 * SUM_W;

  localparam int COEF_W = COEFF_FRAC_BITS;
  localparam int PROD_W = COEF_W + PIX_W;
  localparam int ACC_W  = PROD_W + 1;

  localparam longint unsigned PPM = 64'd1000000;

  // BT.601 full-range coefficients in fixed point, rounded to nearest
  localparam logic [COEF_W-1:0] K_Y_B =
    COEF_W'(((64'd114000 << COEFF_FRAC_BITS) + PPM / 2) / PPM);
  localparam logic [COEF_W-1:0] K_Y_G =
    COEF_W'(((64'd587000 << COEFF_FRAC_BITS) + PPM / 2) / PPM);
  localparam logic [COEF_W-1:0] K_Y_R =
    COEF_W'(((64'd299000 << COEFF_FRAC_BITS) + PPM / 2) / PPM);
  localparam logic [COEF_W-1:0] K_U_B =
    COEF_W'(((64'd500000 << COEFF_FRAC_BITS) + PPM / 2) / PPM);
  localparam logic [COEF_W-1:0] K_U_G =
    COEF_W'(((64'd331264 << COEFF_FRAC_BITS) + PPM / 2) / PPM);
  localparam logic [COEF_W-1:0] K_U_R =
    COEF_W'(((64'd168736 << COEFF_FRAC_BITS) + PPM / 2) / PPM);
  localparam logic [COEF_W-1:0] K_V_R =
    COEF_W'(((64'd500000 << COEFF_FRAC_BITS) + PPM / 2) / PPM);
  localparam logic [COEF_W-1:0] K_V_G =
    COEF_W'(((64'd418688 << COEFF_FRAC_BITS) + PPM / 2) / PPM);
  localparam logic [COEF_W-1:0] K_V_B =
    COEF_W'(((64'd81312 << COEFF_FRAC_BITS) + PPM / 2) / PPM);

  localparam logic [ACC_W-1:0] ACC_OFFSET = ACC_W'(128) << COEFF_FRAC_BITS;
  localparam logic [ACC_W-1:0] ACC_HALF   = ACC_W'(1) << (COEFF_FRAC_BITS - 1);

  localparam logic FMT_YUYV = 1'b0;
  localparam logic FMT_NV12 = 1'b1;

  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_WIDTH  = 1'b1;

  localparam logic [POS_W-1:0] WIDTH_RESET = POS_W'(320);

  typedef enum logic [1:0] {
    KIND_QUAD   = 2'd0,
    KIND_LUMA   = 2'd1,
    KIND_CHROMA = 2'd2
  } kind_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             frame_start;
  } in_req_t;

  typedef struct packed {
    kind_t            kind;
    logic [PIX_W-1:0] byte_a;
    logic [PIX_W-1:0] byte_b;
    logic [PIX_W-1:0] byte_c;
    logic [PIX_W-1:0] byte_d;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic             last_of_item;
  } out_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pix_t;

  typedef struct packed {
    logic [PIX_W-1:0] y;
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] v;
  } yuv_t;

  typedef struct packed {
    logic             valid;
    logic             fmt;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
  } ctrl_t;

endpackage

// ===== hw/rtl/rtyc_color.sv =====
// ----------------------------------------------------------------------------
// rtyc_color
// Two-stage color matrix: constant products, then sum, round and clamp.
// ----------------------------------------------------------------------------
module rtyc_color import rtyc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  ctrl_t s1_ctrl,
  input  pix_t  s1_pix,
  output ctrl_t s2_ctrl,
  output ctrl_t s3_ctrl,
  output yuv_t  s3_yuv
);

  ctrl_t s2_ctrl_r;
  ctrl_t s3_ctrl_r;
  yuv_t  s3_yuv_r;

  logic [PROD_W-1:0] py_b_r, py_g_r, py_r_r;
  logic [PROD_W-1:0] pu_b_r, pu_g_r, pu_r_r;
  logic [PROD_W-1:0] pv_b_r, pv_g_r, pv_r_r;

  logic [ACC_W-1:0] acc_y, acc_u, acc_v;
  yuv_t             yuv_nxt;

  function automatic logic [PIX_W-1:0] round_clamp(input logic [ACC_W-1:0] acc);
    logic [ACC_W-COEFF_FRAC_BITS-1:0] mag;
    mag = acc[ACC_W-1:COEFF_FRAC_BITS];
    if (mag > (ACC_W-COEFF_FRAC_BITS)'(255)) begin
      return PIX_W'(255);
    end
    return mag[PIX_W-1:0];
  endfunction

  // U and V accumulators never go negative with these coefficients
  always_comb begin
    acc_y = ACC_W'(py_b_r) + ACC_W'(py_g_r) + ACC_W'(py_r_r) + ACC_HALF;
    acc_u = ACC_OFFSET + ACC_HALF + ACC_W'(pu_b_r) - ACC_W'(pu_g_r) - ACC_W'(pu_r_r);
    acc_v = ACC_OFFSET + ACC_HALF + ACC_W'(pv_r_r) - ACC_W'(pv_g_r) - ACC_W'(pv_b_r);
    yuv_nxt.y = round_clamp(acc_y);
    yuv_nxt.u = round_clamp(acc_u);
    yuv_nxt.v = round_clamp(acc_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctrl_r <= '0;
      s3_ctrl_r <= '0;
    end else if (adv) begin
      s2_ctrl_r <= s1_ctrl;
      s3_ctrl_r <= s2_ctrl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      py_b_r <= PROD_W'(K_Y_B) * PROD_W'(s1_pix.blue);
      py_g_r <= PROD_W'(K_Y_G) * PROD_W'(s1_pix.green);
      py_r_r <= PROD_W'(K_Y_R) * PROD_W'(s1_pix.red);
      pu_b_r <= PROD_W'(K_U_B) * PROD_W'(s1_pix.blue);
      pu_g_r <= PROD_W'(K_U_G) * PROD_W'(s1_pix.green);
      pu_r_r <= PROD_W'(K_U_R) * PROD_W'(s1_pix.red);
      pv_b_r <= PROD_W'(K_V_B) * PROD_W'(s1_pix.blue);
      pv_g_r <= PROD_W'(K_V_G) * PROD_W'(s1_pix.green);
      pv_r_r <= PROD_W'(K_V_R) * PROD_W'(s1_pix.red);
      s3_yuv_r <= yuv_nxt;
    end
  end

  assign s2_ctrl = s2_ctrl_r;
  assign s3_ctrl = s3_ctrl_r;
  assign s3_yuv  = s3_yuv_r;

endmodule

// ===== hw/rtl/rtyc_chroma.sv =====
// ----------------------------------------------------------------------------
// rtyc_chroma
// Pair averaging, chroma line store and the two-entry result output stage.
// ----------------------------------------------------------------------------
module rtyc_chroma import rtyc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  ctrl_t    s2_ctrl,
  input  ctrl_t    s3_ctrl,
  input  yuv_t     s3_yuv,
  output logic     adv,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data
);

  logic [LS_W-1:0] line_mem [MAX_WIDTH_PAIRS];
  logic [LS_W-1:0] line_rd_r;

  logic [PIX_W-1:0] held_y_r, held_u_r, held_v_r;

  logic     out_valid_r;
  logic     sel_r;
  logic     has2_r;
  out_req_t res0_r, res1_r;

  logic               odd_col, odd_row;
  logic [PAIR_AW-1:0] rd_addr, wr_addr;
  logic               wr_en;
  logic [LS_W-1:0]    wr_data;
  logic [SUM_W-1:0]   sum_u, sum_v;
  logic [SUM_W:0]     quad_u, quad_v;
  logic               any_nxt, has2_nxt;
  out_req_t           res0_nxt, res1_nxt;

  assign odd_col = s3_ctrl.column[0];
  assign odd_row = s3_ctrl.row[0];
  assign rd_addr = PAIR_AW'(s2_ctrl.column >> 1);
  assign wr_addr = PAIR_AW'(s3_ctrl.column >> 1);

  assign sum_u  = SUM_W'(held_u_r) + SUM_W'(s3_yuv.u);
  assign sum_v  = SUM_W'(held_v_r) + SUM_W'(s3_yuv.v);
  assign quad_u = (SUM_W+1)'(line_rd_r[LS_W-1:SUM_W]) + (SUM_W+1)'(sum_u);
  assign quad_v = (SUM_W+1)'(line_rd_r[SUM_W-1:0]) + (SUM_W+1)'(sum_v);

  assign wr_en   = adv && s3_ctrl.valid && (s3_ctrl.fmt == FMT_NV12) && odd_col && !odd_row;
  assign wr_data = {sum_u, sum_v};

  always_comb begin
    res0_nxt        = '0;
    res0_nxt.row    = s3_ctrl.row;
    res0_nxt.column = s3_ctrl.column;
    res1_nxt        = res0_nxt;
    any_nxt         = 1'b0;
    has2_nxt        = 1'b0;
    case (s3_ctrl.fmt)
      FMT_YUYV: begin
        any_nxt               = odd_col;
        res0_nxt.kind         = KIND_QUAD;
        res0_nxt.byte_a       = held_y_r;
        res0_nxt.byte_b       = sum_u[SUM_W-1:1];
        res0_nxt.byte_c       = s3_yuv.y;
        res0_nxt.byte_d       = sum_v[SUM_W-1:1];
        res0_nxt.last_of_item = 1'b1;
      end
      FMT_NV12: begin
        any_nxt               = 1'b1;
        has2_nxt              = odd_col && odd_row;
        res0_nxt.kind         = KIND_LUMA;
        res0_nxt.byte_a       = s3_yuv.y;
        res0_nxt.last_of_item = !(odd_col && odd_row);
        res1_nxt.kind         = KIND_CHROMA;
        res1_nxt.byte_a       = quad_u[SUM_W:2];
        res1_nxt.byte_b       = quad_v[SUM_W:2];
        res1_nxt.last_of_item = 1'b1;
      end
      default: begin
        any_nxt = 1'b0;
      end
    endcase
  end

  // read data follows the item into stage 3; same-edge write is bypassed
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
    if (adv) begin
      line_rd_r <= (wr_en && (wr_addr == rd_addr)) ? wr_data : line_mem[rd_addr];
    end
  end

  assign adv = !out_valid_r || (!out_stall && (sel_r || !has2_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
      has2_r      <= 1'b0;
      held_y_r    <= '0;
      held_u_r    <= '0;
      held_v_r    <= '0;
    end else if (adv) begin
      out_valid_r <= s3_ctrl.valid && any_nxt;
      sel_r       <= 1'b0;
      has2_r      <= has2_nxt;
      if (s3_ctrl.valid && !odd_col) begin
        held_y_r <= s3_yuv.y;
        held_u_r <= s3_yuv.u;
        held_v_r <= s3_yuv.v;
      end
    end else if (!out_stall) begin
      sel_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res0_r <= res0_nxt;
      res1_r <= res1_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = sel_r ? res1_r : res0_r;

endmodule

// ===== hw/rtl/rgb_to_yuv_subsampled_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_yuv_subsampled_converter
// BT.601 full-range BGR to YUYV 4:2:2 or NV12 4:2:0 converter, raster order.
// ----------------------------------------------------------------------------
// One pixel is accepted per clock while the output stage does not pause the
// input. Pauses come from out_stall and from an NV12 pixel on an odd row and
// odd column: it gives a luma byte and a chroma pair, which leave one after
// the other, so the input takes no new pixel until the chroma pair leaves.
// Chroma pair sums of even NV12 rows sit in a single-port-read, single-port-
// write line store of MAX_WIDTH_PAIRS entries; it is not cleared after reset,
// and an odd NV12 row must follow an even row stored in NV12 mode. Write the
// registers only while no pixel is in flight.
// ----------------------------------------------------------------------------
module rgb_to_yuv_subsampled_converter import rtyc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_req_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             fmt_r;
  logic [POS_W-1:0] width_r;
  logic [POS_W-1:0] column_r, column_nxt;
  logic [POS_W-1:0] row_r, row_nxt;
  ctrl_t            s1_ctrl_r;
  pix_t             s1_pix_r;

  ctrl_t            s2_ctrl, s3_ctrl;
  yuv_t             s3_yuv;
  logic             adv;
  logic             accept;
  logic             cfg_wr;
  logic [POS_W-1:0] col_cur, row_cur;
  logic [POS_W:0]   pairs;
  logic [POS_W+1:0] width_px;
  logic             row_end;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      REG_FORMAT: prdata = {31'b0, fmt_r};
      REG_WIDTH:  prdata = {{(32-POS_W){1'b0}}, width_r};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_YUYV;
      width_r <= WIDTH_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FORMAT: fmt_r   <= pwdata[0];
        REG_WIDTH:  width_r <= pwdata[POS_W-1:0];
        default:    fmt_r   <= fmt_r;
      endcase
    end
  end

  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  always_comb begin
    col_cur = in_data.frame_start ? '0 : column_r;
    row_cur = in_data.frame_start ? '0 : row_r;
    if (width_r == '0) begin
      pairs = (POS_W+1)'(1);
    end else if (32'(width_r) > MAX_WIDTH_PAIRS) begin
      pairs = (POS_W+1)'(MAX_WIDTH_PAIRS);
    end else begin
      pairs = (POS_W+1)'(width_r);
    end
    width_px   = {pairs, 1'b0};
    row_end    = ((POS_W+2)'(col_cur) + (POS_W+2)'(1)) >= width_px;
    column_nxt = row_end ? '0 : col_cur + POS_W'(1);
    row_nxt    = row_end ? row_cur + POS_W'(1) : row_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r  <= '0;
      row_r     <= '0;
      s1_ctrl_r <= '0;
    end else begin
      if (accept) begin
        column_r <= column_nxt;
        row_r    <= row_nxt;
      end
      if (adv) begin
        s1_ctrl_r.valid  <= accept;
        s1_ctrl_r.fmt    <= fmt_r;
        s1_ctrl_r.row    <= row_cur;
        s1_ctrl_r.column <= col_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix_r.blue  <= in_data.blue;
      s1_pix_r.green <= in_data.green;
      s1_pix_r.red   <= in_data.red;
    end
  end

  rtyc_color u_color (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .s1_ctrl (s1_ctrl_r),
    .s1_pix  (s1_pix_r),
    .s2_ctrl (s2_ctrl),
    .s3_ctrl (s3_ctrl),
    .s3_yuv  (s3_yuv)
  );

  rtyc_chroma u_chroma (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_ctrl   (s2_ctrl),
    .s3_ctrl   (s3_ctrl),
    .s3_yuv    (s3_yuv),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
